// ===== hdl/sorted_key_node_engine_unit_assert.svh =====
// Assertion macros for the sorted key node engine.
// Used at the end of the top level; expects clk and arst_n in scope.
`ifndef SORTED_KEY_NODE_ENGINE_UNIT_ASSERT_SVH
`define SORTED_KEY_NODE_ENGINE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKNE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SKNE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/skne_pkg.sv =====
// Shared types, field widths and codes of the sorted key node engine.
// No dependencies; used by the controller, the datapath and the top level.
package skne_pkg;

	localparam int CAPACITY_DEF  = 64;
	localparam int KEY_WIDTH_DEF = 32;

	localparam int OPC_W  = 3;
	localparam int KEY_W  = 32;
	localparam int PAGE_W = 32;
	localparam int SLOT_W = 17;
	localparam int POS_W  = 6;
	localparam int STAT_W = 2;
	localparam int IDX_W  = 7;

	localparam int S_TDATA_W = 88;
	localparam int M_TDATA_W = 96;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	// paddr[2] selects the register word; word 0 is node_is_leaf.
	localparam logic REG_NODE_IS_LEAF = 1'b0;

	typedef logic [OPC_W-1:0]  opcode_t;
	typedef logic [STAT_W-1:0] status_t;

	localparam opcode_t OP_INSERT = 3'd0;
	localparam opcode_t OP_REMOVE = 3'd1;
	localparam opcode_t OP_LOOKUP = 3'd2;
	localparam opcode_t OP_ROUTE  = 3'd3;
	localparam opcode_t OP_LOWER  = 3'd4;
	localparam opcode_t OP_UPPER  = 3'd5;
	localparam opcode_t OP_READ   = 3'd6;

	localparam status_t STAT_OK       = 2'd0;
	localparam status_t STAT_DUP      = 2'd1;
	localparam status_t STAT_NOTFOUND = 2'd2;
	localparam status_t STAT_FULL     = 2'd3;

	typedef struct packed {
		logic load;
		logic srch_rd;
		logic srch_upd;
		logic fetch_rd;
		logic emit;
		logic sh_step;
		logic sh_done;
	} cmd_t;

	typedef struct packed {
		logic srch_more;
		logic out_busy;
		logic need_shift;
		logic sh_more;
		logic sh_busy;
	} sts_t;

endpackage

// ===== hdl/skne_ctrl.sv =====
// Controller state machine of the sorted key node engine.
// Depends on skne_pkg for the command and status structs.
module skne_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  skne_pkg::sts_t sts,
	output logic          s_tready,
	output skne_pkg::cmd_t cmd
);
	import skne_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SRCH  = 3'd1;
	localparam logic [2:0] S_SCMP  = 3'd2;
	localparam logic [2:0] S_EVAL  = 3'd3;
	localparam logic [2:0] S_SHIFT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_SRCH;
				end
			end
			S_SRCH: begin
				// Each probe reads one entry; when the range is empty the
				// entry at the found position is fetched instead.
				if (sts.srch_more) begin
					cmd.srch_rd = 1'b1;
					state_d     = S_SCMP;
				end else begin
					cmd.fetch_rd = 1'b1;
					state_d      = S_EVAL;
				end
			end
			S_SCMP: begin
				cmd.srch_upd = 1'b1;
				state_d      = S_SRCH;
			end
			S_EVAL: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = sts.need_shift ? S_SHIFT : S_IDLE;
				end
			end
			S_SHIFT: begin
				if (sts.sh_more || sts.sh_busy) begin
					cmd.sh_step = 1'b1;
				end else begin
					cmd.sh_done = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/skne_dpath.sv =====
// Datapath of the sorted key node engine: entry memory, search bounds,
// shift pointer and the result register. Depends on skne_pkg.
module skne_dpath #(
	parameter int CAPACITY  = skne_pkg::CAPACITY_DEF,
	parameter int KEY_WIDTH = skne_pkg::KEY_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  skne_pkg::cmd_t                       cmd,
	input  logic                                 node_is_leaf,
	input  skne_pkg::opcode_t                    in_opcode,
	input  logic [skne_pkg::KEY_W-1:0]           in_key,
	input  logic signed [skne_pkg::PAGE_W-1:0]   in_page,
	input  logic signed [skne_pkg::SLOT_W-1:0]   in_slot,
	input  logic [skne_pkg::POS_W-1:0]           in_pos,
	input  logic                                 m_tready,
	output skne_pkg::sts_t                       sts,
	output logic                                 m_tvalid,
	output skne_pkg::status_t                    out_status,
	output logic [skne_pkg::IDX_W-1:0]           out_index,
	output logic [skne_pkg::KEY_W-1:0]           out_key,
	output logic signed [skne_pkg::PAGE_W-1:0]   out_page,
	output logic signed [skne_pkg::SLOT_W-1:0]   out_slot,
	output logic [skne_pkg::IDX_W-1:0]           out_count
);
	import skne_pkg::*;

	localparam int AW    = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SKW   = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
	localparam int CMPW  = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int EW    = SKW + PAGE_W + SLOT_W;

	logic [EW-1:0] mem_q [CAPACITY];

	opcode_t                  op_q;
	logic [SKW-1:0]           key_q;
	logic signed [PAGE_W-1:0] page_q;
	logic signed [SLOT_W-1:0] slot_q;
	logic [POS_W-1:0]         pos_q;
	logic [CNT_W-1:0]         lo_q;
	logic [CNT_W-1:0]         hi_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         ptr_q;
	logic [CNT_W-1:0]         lim_q;
	logic                     sh_ins_q;
	logic                     sh_vld_s1;
	logic [AW-1:0]            sh_dst_s1;
	logic [EW-1:0]            rd_q;
	logic                     m_tvalid_q;
	status_t                  out_status_q;
	logic [IDX_W-1:0]         out_index_q;
	logic [KEY_W-1:0]         out_key_q;
	logic signed [PAGE_W-1:0] out_page_q;
	logic signed [SLOT_W-1:0] out_slot_q;
	logic [IDX_W-1:0]         out_count_q;

	logic [SKW-1:0]           rd_key;
	logic signed [PAGE_W-1:0] rd_page;
	logic signed [SLOT_W-1:0] rd_slot;
	logic [CNT_W:0]           mid_sum;
	logic [CNT_W-1:0]         mid;
	logic [CNT_W-1:0]         lo_m1;
	logic                     is_upper;
	logic                     go_left;
	logic [CMPW-1:0]          tgt;
	logic                     ent_ok;
	logic                     key_eq;
	logic                     full;
	logic                     sh_more;
	logic [CNT_W-1:0]         lo_init;
	logic [CNT_W-1:0]         hi_init;

	status_t                  res_status;
	logic [CNT_W-1:0]         res_idx;
	logic                     res_use_rd;
	logic                     res_use_new;
	logic [CNT_W-1:0]         res_cnt;
	logic                     res_shift;
	logic                     res_ins;

	logic                     rd_en;
	logic [AW-1:0]            rd_addr;
	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	logic [EW-1:0]            wr_data;

	assign rd_key  = rd_q[EW-1 -: SKW];
	assign rd_page = rd_q[PAGE_W+SLOT_W-1 -: PAGE_W];
	assign rd_slot = rd_q[SLOT_W-1:0];

	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = mid_sum[CNT_W:1];
	assign lo_m1    = lo_q - CNT_W'(1);
	assign is_upper = (op_q == OP_ROUTE) || (op_q == OP_UPPER);
	assign go_left  = is_upper ? (rd_key > key_q) : (rd_key >= key_q);
	assign full     = (cnt_q == CNT_W'(CAPACITY));
	assign sh_more  = sh_ins_q ? (ptr_q > lo_q) : (ptr_q < lim_q);

	always_comb begin
		lo_init = '0;
		hi_init = '0;
		unique case (in_opcode)
			OP_INSERT, OP_REMOVE, OP_LOOKUP, OP_LOWER: begin
				hi_init = cnt_q;
			end
			OP_ROUTE, OP_UPPER: begin
				// An internal node never searches its first entry.
				lo_init = node_is_leaf ? CNT_W'(0) : CNT_W'(1);
				hi_init = cnt_q;
			end
			default: begin
				lo_init = '0;
				hi_init = '0;
			end
		endcase
	end

	always_comb begin
		tgt    = CMPW'(lo_q);
		ent_ok = 1'b0;
		unique case (op_q)
			OP_INSERT, OP_REMOVE, OP_LOOKUP, OP_LOWER, OP_UPPER: begin
				ent_ok = (lo_q < cnt_q);
			end
			OP_ROUTE: begin
				tgt    = CMPW'(lo_m1);
				ent_ok = (lo_q != '0) && (cnt_q != '0);
			end
			OP_READ: begin
				tgt    = CMPW'(pos_q);
				ent_ok = (CMPW'(pos_q) < CMPW'(cnt_q));
			end
			default: begin
				ent_ok = 1'b0;
			end
		endcase
	end

	assign key_eq = ent_ok && (rd_key == key_q);

	always_comb begin
		res_status  = STAT_NOTFOUND;
		res_idx     = lo_q;
		res_use_rd  = 1'b0;
		res_use_new = 1'b0;
		res_cnt     = cnt_q;
		res_shift   = 1'b0;
		res_ins     = 1'b0;
		unique case (op_q)
			OP_INSERT: begin
				if (key_eq) begin
					res_status = STAT_DUP;
					res_use_rd = 1'b1;
				end else if (full) begin
					res_status = STAT_FULL;
				end else begin
					res_status  = STAT_OK;
					res_use_new = 1'b1;
					res_cnt     = cnt_q + CNT_W'(1);
					res_shift   = 1'b1;
					res_ins     = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (key_eq) begin
					res_status = STAT_OK;
					res_use_rd = 1'b1;
					res_cnt    = cnt_q - CNT_W'(1);
					res_shift  = 1'b1;
				end
			end
			OP_LOOKUP: begin
				if (key_eq) begin
					res_status = STAT_OK;
					res_use_rd = 1'b1;
				end
			end
			OP_ROUTE: begin
				res_idx = '0;
				if (ent_ok) begin
					res_status = STAT_OK;
					res_use_rd = 1'b1;
					res_idx    = lo_m1;
				end
			end
			OP_LOWER, OP_UPPER, OP_READ: begin
				if (ent_ok) begin
					res_status = STAT_OK;
					res_use_rd = 1'b1;
				end
			end
			default: begin
				res_idx = '0;
			end
		endcase
	end

	// Insert moves entries up from the top down; remove moves them down from
	// the bottom up. Reads stay ahead of the trailing write either way.
	always_comb begin
		rd_en   = cmd.srch_rd || cmd.fetch_rd || (cmd.sh_step && sh_more);
		rd_addr = AW'(ptr_q);
		if (cmd.srch_rd) begin
			rd_addr = AW'(mid);
		end else if (cmd.fetch_rd) begin
			rd_addr = AW'(tgt);
		end else if (sh_ins_q) begin
			rd_addr = AW'(ptr_q - CNT_W'(1));
		end
	end

	assign wr_en   = sh_vld_s1 || (cmd.sh_done && sh_ins_q);
	assign wr_addr = sh_vld_s1 ? sh_dst_s1 : AW'(lo_q);
	assign wr_data = sh_vld_s1 ? rd_q : {key_q, page_q, slot_q};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= in_opcode;
			key_q  <= in_key[SKW-1:0];
			page_q <= in_page;
			slot_q <= in_slot;
			pos_q  <= in_pos;
			lo_q   <= lo_init;
			hi_q   <= hi_init;
		end else if (cmd.srch_upd) begin
			if (go_left) begin
				hi_q <= mid;
			end else begin
				lo_q <= mid + CNT_W'(1);
			end
		end
		if (cmd.emit) begin
			out_status_q <= res_status;
			out_index_q  <= (op_q == OP_READ) ? IDX_W'(pos_q) : IDX_W'(res_idx);
			out_count_q  <= IDX_W'(res_cnt);
			if (res_use_rd) begin
				out_key_q  <= KEY_W'(rd_key);
				out_page_q <= rd_page;
				out_slot_q <= rd_slot;
			end else if (res_use_new) begin
				out_key_q  <= KEY_W'(key_q);
				out_page_q <= page_q;
				out_slot_q <= slot_q;
			end else begin
				out_key_q  <= '0;
				out_page_q <= '0;
				out_slot_q <= '0;
			end
			ptr_q <= res_ins ? cnt_q : (lo_q + CNT_W'(1));
			lim_q <= cnt_q;
		end else if (cmd.sh_step && sh_more) begin
			ptr_q <= sh_ins_q ? (ptr_q - CNT_W'(1)) : (ptr_q + CNT_W'(1));
		end
		if (cmd.sh_step && sh_more) begin
			sh_dst_s1 <= sh_ins_q ? AW'(ptr_q) : AW'(ptr_q - CNT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			sh_ins_q   <= 1'b0;
			sh_vld_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			sh_vld_s1 <= cmd.sh_step && sh_more;
			if (cmd.emit) begin
				cnt_q      <= res_cnt;
				sh_ins_q   <= res_ins;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign sts.srch_more  = (lo_q < hi_q);
	assign sts.out_busy   = m_tvalid_q && !m_tready;
	assign sts.need_shift = res_shift;
	assign sts.sh_more    = sh_more;
	assign sts.sh_busy    = sh_vld_s1;

	assign m_tvalid   = m_tvalid_q;
	assign out_status = out_status_q;
	assign out_index  = out_index_q;
	assign out_key    = out_key_q;
	assign out_page   = out_page_q;
	assign out_slot   = out_slot_q;
	assign out_count  = out_count_q;

endmodule

// ===== hdl/sorted_key_node_engine_unit.sv =====
// Top level of the sorted key node engine: stream ports, APB register,
// controller and datapath. Depends on skne_pkg, skne_ctrl, skne_dpath and the assertion header.
//
// One B+ tree node held as a sorted array of up to CAPACITY entries in a
// memory with one read and one write port; one item is in work at a time,
// and each produces one result beat. Each probe of the binary search reads
// an entry from memory and then compares it with the key; the item is first
// loaded, and after the search the found entry is fetched and the result
// presented. Insert and remove then move one entry per cycle. The result
// register lets a finished beat wait on m_tready while the node finishes
// its shift; a new item is taken once the previous one is complete.
// node_is_leaf sits at byte address 0.
`include "sorted_key_node_engine_unit_assert.svh"

module sorted_key_node_engine_unit #(
	parameter int CAPACITY  = skne_pkg::CAPACITY_DEF,
	parameter int KEY_WIDTH = skne_pkg::KEY_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// search_key[31:0], in_page[63:32], in_slot[80:64], position[86:81]
	input  logic [skne_pkg::S_TDATA_W-1:0]      s_tdata,
	// opcode[2:0]
	input  logic [skne_pkg::OPC_W-1:0]          s_tuser,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// index[6:0], out_key[38:7], out_page[70:39], out_slot[87:71],
	// entry_count[94:88]
	output logic [skne_pkg::M_TDATA_W-1:0]      m_tdata,
	// status[1:0]
	output logic [skne_pkg::STAT_W-1:0]         m_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [skne_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [skne_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [skne_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);
	import skne_pkg::*;

	logic                     leaf_q;
	cmd_t                     cmd;
	sts_t                     sts;
	status_t                  o_status;
	logic [IDX_W-1:0]         o_index;
	logic [KEY_W-1:0]         o_key;
	logic signed [PAGE_W-1:0] o_page;
	logic signed [SLOT_W-1:0] o_slot;
	logic [IDX_W-1:0]         o_count;
	logic                     full_beat;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_NODE_IS_LEAF) ? APB_DATA_W'(leaf_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_q <= 1'b1;
		end else if (psel && penable && pwrite && pready &&
			(paddr[2] == REG_NODE_IS_LEAF)) begin
			leaf_q <= pwdata[0];
		end
	end

	skne_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.sts      (sts),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	skne_dpath #(
		.CAPACITY  (CAPACITY),
		.KEY_WIDTH (KEY_WIDTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.node_is_leaf (leaf_q),
		.in_opcode    (s_tuser),
		.in_key       (s_tdata[31:0]),
		.in_page      (s_tdata[63:32]),
		.in_slot      (s_tdata[80:64]),
		.in_pos       (s_tdata[86:81]),
		.m_tready     (m_tready),
		.sts          (sts),
		.m_tvalid     (m_tvalid),
		.out_status   (o_status),
		.out_index    (o_index),
		.out_key      (o_key),
		.out_page     (o_page),
		.out_slot     (o_slot),
		.out_count    (o_count)
	);

	assign m_tuser = o_status;
	assign m_tdata = {1'b0, o_count, o_slot, o_page, o_key, o_index};

	assign full_beat = m_tvalid && (o_status == STAT_FULL);

	// Only one item is in work, so an accepted beat closes the input side.
	`SKNE_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken")
	// A refused insert is only reported for a node at capacity.
	`SKNE_ASSERT_SAME(a_full_cnt, full_beat, o_count == IDX_W'(CAPACITY), "full below capacity")
	// A new result only appears while an item is in work.
	`SKNE_ASSERT_SAME(a_res_busy, $rose(m_tvalid), !$past(s_tready), "result while idle")

endmodule
